@@ sv/hlpd_pkg.sv @@
// Package with types, constants and helper functions for the hex length prefixed deframer.
`timescale 1ns / 1ps
package hlpd_pkg;

    // Result queue sizing.
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Header and length constants.
    localparam int HDR_DIGITS = 4;
    localparam logic [15:0] LEN_FLUSH = 16'd0;
    localparam logic [15:0] LEN_DELIM = 16'd1;
    localparam logic [15:0] LEN_HDR   = 16'd4;

    // Stream widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 4;

    typedef enum logic [2:0] {
        K_DATA  = 3'd0,
        K_FLUSH = 3'd1,
        K_DELIM = 3'd2,
        K_ERROR = 3'd3,
        K_EMPTY = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DISCARD = 2'd2,
        PH_SPARE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic        run_last;
        logic        packet_last;
        logic [15:0] payload_length;
        logic [7:0]  payload_byte;
        t_kind       kind;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_nibble;

    // Decode one ASCII hex digit, upper or lower case.
    function automatic t_nibble nibble_of(input logic [7:0] c);
        t_nibble n;
        n.ok    = 1'b1;
        n.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n.value = c[3:0];
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            n.value = c[3:0] + 4'd9;
        end else begin
            n.ok = 1'b0;
        end
        return n;
    endfunction

    // A result that carries only a kind code.
    function automatic t_result code_result(input t_kind k);
        t_result r;
        r = '0;
        r.kind = k;
        return r;
    endfunction

endpackage

@@ sv/hex_length_prefixed_deframer_top.sv @@
// Hex length prefixed deframer: parses four digit headers and forwards payload bytes.
// Each result is written into the result queue at the edge that accepts its byte.
// Throughput: one input byte per cycle while tready is high; a byte that ends a buffer
// inside a payload yields two results, which the four entry result queue absorbs.
// The slave side accepts a byte while the queue has room for two results.
// Reset is synchronous and active low; it returns the parser to the header phase
// and empties the result queue.
`timescale 1ns / 1ps
module hex_length_prefixed_deframer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata fields from bit 0 up: byte_in[7:0].
    input  logic [hlpd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // tlast carries buffer_end.
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // tdata fields from bit 0 up: payload_byte[7:0], payload_length[23:8].
    output logic [hlpd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // tuser fields from bit 0 up: kind[2:0], run_last[3].
    output logic [hlpd_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,
    // tlast carries packet_last.
    output logic                                m_axis_tlast
);
    import hlpd_pkg::*;

    t_phase              r_phase, n_phase;
    logic [1:0]          r_digit_count, n_digit_count;
    logic [15:0]         r_length_accum, n_length_accum;
    logic [15:0]         r_bytes_left, n_bytes_left;

    t_result             r_fifo [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;

    logic                in_req, out_req;
    logic [7:0]          in_byte;
    logic                in_last;
    t_nibble             nib;
    logic [15:0]         acc_next;
    logic                fin;
    logic [1:0]          push_cnt;
    t_result             res0, res1;

    assign in_byte = s_axis_tdata[7:0];
    assign in_last = s_axis_tlast;
    assign s_axis_tready = (r_count <= QCNT_W'(QDEPTH - 2));
    assign in_req  = s_axis_tvalid && s_axis_tready;
    assign out_req = m_axis_tvalid && m_axis_tready;

    assign nib      = nibble_of(in_byte);
    assign acc_next = {r_length_accum[11:0], nib.value};
    assign fin      = (r_bytes_left <= 16'd1);

    // Parser step for one byte: next state and up to two results.
    always_comb begin
        n_phase        = r_phase;
        n_digit_count  = r_digit_count;
        n_length_accum = r_length_accum;
        n_bytes_left   = r_bytes_left;
        res0           = '0;
        res1           = '0;
        push_cnt       = 2'd0;
        unique case (r_phase)
            PH_PAYLOAD: begin
                res0.kind           = K_DATA;
                res0.payload_byte   = in_byte;
                res0.payload_length = r_length_accum - LEN_HDR;
                res0.packet_last    = fin;
                push_cnt            = 2'd1;
                n_bytes_left        = r_bytes_left - 16'd1;
                if (fin || in_last) begin
                    n_phase        = PH_HEADER;
                    n_digit_count  = 2'd0;
                    n_length_accum = '0;
                    n_bytes_left   = '0;
                end
                if (!fin && in_last) begin
                    res1     = code_result(K_ERROR);
                    push_cnt = 2'd2;
                end
            end
            PH_DISCARD: begin
                if (in_last) begin
                    n_phase        = PH_HEADER;
                    n_digit_count  = 2'd0;
                    n_length_accum = '0;
                    n_bytes_left   = '0;
                end
            end
            PH_HEADER, PH_SPARE: begin
                // Any outcome other than a digit that continues the header, opens a payload
                // or starts a discard returns to a clean header state.
                n_phase        = PH_HEADER;
                n_digit_count  = 2'd0;
                n_length_accum = '0;
                n_bytes_left   = '0;
                push_cnt       = 2'd1;
                res0           = code_result(K_ERROR);
                if (!nib.ok) begin
                    if (!in_last) begin
                        n_phase = PH_DISCARD;
                    end
                end else if (r_digit_count < 2'(HDR_DIGITS - 1)) begin
                    if (!in_last) begin
                        n_digit_count  = r_digit_count + 2'd1;
                        n_length_accum = acc_next;
                        push_cnt       = 2'd0;
                    end
                end else begin
                    priority if (acc_next == LEN_FLUSH) begin
                        res0 = code_result(K_FLUSH);
                    end else if (acc_next == LEN_DELIM) begin
                        res0 = code_result(K_DELIM);
                    end else if (acc_next < LEN_HDR) begin
                        if (!in_last) begin
                            n_phase = PH_DISCARD;
                        end
                    end else if (acc_next == LEN_HDR) begin
                        res0 = code_result(K_EMPTY);
                    end else if (in_last) begin
                        res0 = code_result(K_ERROR);
                    end else begin
                        n_phase        = PH_PAYLOAD;
                        n_length_accum = acc_next;
                        n_bytes_left   = acc_next - LEN_HDR;
                        push_cnt       = 2'd0;
                    end
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase
        // The last result of a byte carries the run mark.
        if (push_cnt == 2'd2) begin
            res1.run_last = 1'b1;
        end else begin
            res0.run_last = 1'b1;
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_digit_count  <= '0;
            r_length_accum <= '0;
            r_bytes_left   <= '0;
        end else if (in_req) begin
            r_phase        <= n_phase;
            r_digit_count  <= n_digit_count;
            r_length_accum <= n_length_accum;
            r_bytes_left   <= n_bytes_left;
        end
    end

    // Result queue storage.
    always_ff @(posedge i_clk) begin
        if (in_req && push_cnt != 2'd0) begin
            r_fifo[r_wr_ptr] <= res0;
        end
        if (in_req && push_cnt == 2'd2) begin
            r_fifo[r_wr_ptr + QPTR_W'(1)] <= res1;
        end
    end

    // Result queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (in_req) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(push_cnt);
            end
            if (out_req) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + (in_req ? QCNT_W'(push_cnt) : QCNT_W'(0))
                       - (out_req ? QCNT_W'(1) : QCNT_W'(0));
        end
    end

    // Master side driven from the queue head.
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {r_fifo[r_rd_ptr].payload_length, r_fifo[r_rd_ptr].payload_byte};
    assign m_axis_tuser  = {r_fifo[r_rd_ptr].run_last, r_fifo[r_rd_ptr].kind};
    assign m_axis_tlast  = r_fifo[r_rd_ptr].packet_last;

endmodule

@@ sim/tb_hex_length_prefixed_deframer_top.sv @@
// Self-checking testbench for the hex length prefixed deframer top level.
`timescale 1ns / 1ps
module tb_hex_length_prefixed_deframer_top;
    import hlpd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int TARGET_BYTES = 1650;

    // Boundary characters just outside the hex digit ranges.
    localparam logic [7:0] NEAR_HEX [6] = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67};

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // byte_in[7:0]
    logic                   s_axis_tlast;   // buffer_end
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // payload_byte[7:0], payload_length[23:8]
    logic [OUT_TUSER_W-1:0] m_axis_tuser;   // kind[2:0], run_last[3]
    logic                   m_axis_tlast;   // packet_last

    // Deframer state mirrored by the predictor.
    t_phase      parse_phase = PH_HEADER;
    logic [1:0]  digits_seen = '0;
    logic [15:0] header_len  = '0;
    logic [15:0] bytes_owed  = '0;

    t_result     pending[$];
    logic [7:0]  frame_bytes[$];
    int          errors       = 0;
    int          bytes_sent   = 0;
    int          cycle_count  = 0;
    int          stall_request = 0;
    bit          src_idle_on  = 1'b1;
    bit          sink_idle_on = 1'b1;

    hex_length_prefixed_deframer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Run time guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic note_failure(input string what);
        errors++;
        if (errors <= 10) begin
            $display("%s", what);
        end
    endtask

    // Value of an ASCII hex digit, or -1 for any other byte.
    function automatic int hex_value(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void parser_to_header();
        parse_phase = PH_HEADER;
        digits_seen = '0;
        header_len  = '0;
        bytes_owed  = '0;
    endfunction

    function automatic void expect_out(input t_kind k, input logic [7:0] b,
                                       input logic [15:0] len, input logic plast);
        t_result r;
        r                = '0;
        r.kind           = k;
        r.payload_byte   = b;
        r.payload_length = len;
        r.packet_last    = plast;
        pending.push_back(r);
    endfunction

    // Expected results for one accepted byte.
    function automatic void predict_byte(input logic [7:0] b, input logic last);
        int   queued;
        int   h;
        logic fin;
        queued = pending.size();
        case (parse_phase)
            PH_PAYLOAD: begin
                fin = (bytes_owed <= 16'd1);
                expect_out(K_DATA, b, header_len - LEN_HDR, fin);
                bytes_owed = bytes_owed - 16'd1;
                if (fin) begin
                    parser_to_header();
                end else if (last) begin
                    expect_out(K_ERROR, '0, '0, 1'b0);
                    parser_to_header();
                end
            end
            PH_DISCARD: begin
                if (last) parser_to_header();
            end
            default: begin
                h = hex_value(b);
                if (h < 0) begin
                    // Bad digit: discard to the buffer end unless this is it.
                    expect_out(K_ERROR, '0, '0, 1'b0);
                    parser_to_header();
                    if (!last) parse_phase = PH_DISCARD;
                end else begin
                    header_len = {header_len[11:0], h[3:0]};
                    if (digits_seen < 2'd3) begin
                        digits_seen++;
                        if (last) begin
                            expect_out(K_ERROR, '0, '0, 1'b0);
                            parser_to_header();
                        end
                    end else begin
                        digits_seen = '0;
                        if (header_len == LEN_FLUSH) begin
                            expect_out(K_FLUSH, '0, '0, 1'b0);
                            parser_to_header();
                        end else if (header_len == LEN_DELIM) begin
                            expect_out(K_DELIM, '0, '0, 1'b0);
                            parser_to_header();
                        end else if (header_len < LEN_HDR) begin
                            expect_out(K_ERROR, '0, '0, 1'b0);
                            parser_to_header();
                            if (!last) parse_phase = PH_DISCARD;
                        end else if (header_len == LEN_HDR) begin
                            expect_out(K_EMPTY, '0, '0, 1'b0);
                            parser_to_header();
                        end else if (last) begin
                            expect_out(K_ERROR, '0, '0, 1'b0);
                            parser_to_header();
                        end else begin
                            parse_phase = PH_PAYLOAD;
                            bytes_owed  = header_len - LEN_HDR;
                        end
                    end
                end
            end
        endcase
        if (pending.size() > queued) pending[pending.size() - 1].run_last = 1'b1;
    endfunction

    // Offer one byte and wait for the request to be taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        if (src_idle_on && $urandom_range(99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_byte(b, last);
        bytes_sent++;
    endtask

    // Send the assembled buffer, marking its final byte.
    task automatic send_buffer();
        for (int i = 0; i < frame_bytes.size(); i++) begin
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        end
        frame_bytes.delete();
    endtask

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + 8'(v);
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    function automatic void add_header(input logic [15:0] len);
        for (int i = 3; i >= 0; i--) frame_bytes.push_back(hex_char(len[4*i +: 4]));
    endfunction

    function automatic void add_random_bytes(input int n);
        for (int i = 0; i < n; i++) frame_bytes.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void add_hex_digits(input int n);
        for (int i = 0; i < n; i++) frame_bytes.push_back(hex_char(4'($urandom_range(15))));
    endfunction

    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        if ($urandom_range(1)) return NEAR_HEX[$urandom_range(5)];
        do c = 8'($urandom_range(255)); while (hex_value(c) >= 0);
        return c;
    endfunction

    // One buffer of mostly well-formed packets, often closed by a broken tail.
    task automatic send_random_buffer();
        int r;
        int plen;
        for (int p = $urandom_range(1, 4); p > 0; p--) begin
            r = $urandom_range(99);
            if (r < 8) begin
                add_header(LEN_FLUSH);
            end else if (r < 16) begin
                add_header(LEN_DELIM);
            end else if (r < 24) begin
                add_header(LEN_HDR);
            end else begin
                plen = ($urandom_range(9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 12);
                add_header(16'(plen + 4));
                add_random_bytes(plen);
            end
        end
        r = $urandom_range(99);
        if (r < 60) begin
            // Well formed to the end.
        end else if (r < 66) begin
            add_hex_digits($urandom_range(1, 3));
        end else if (r < 72) begin
            plen = $urandom_range(2, 30);
            add_header(16'(plen + 4));
            add_random_bytes($urandom_range(1, plen - 1));
        end else if (r < 76) begin
            add_header(16'($urandom_range(5, 200)));
        end else if (r < 82) begin
            add_hex_digits($urandom_range(0, 3));
            frame_bytes.push_back(bad_char());
            add_random_bytes($urandom_range(0, 6));
        end else if (r < 87) begin
            add_header(16'($urandom_range(2, 3)));
            add_random_bytes($urandom_range(0, 6));
        end else if (r < 92) begin
            add_random_bytes($urandom_range(1, 12));
        end else begin
            // Long announced payload cut short by the buffer end.
            add_header(16'($urandom_range('h1000, 'hFFFF)));
            add_random_bytes($urandom_range(1, 8));
        end
        send_buffer();
    endtask

    // Stop offering and wait on clock edges until every expected result has drained.
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending.size() != 0);
    endtask

    // Control packets, bad length, bad digit, extreme length and truncations.
    task automatic test_control_packets();
        add_header(LEN_FLUSH);
        add_header(LEN_DELIM);
        add_header(LEN_HDR);
        send_buffer();
        add_header(16'd2);
        frame_bytes.push_back(8'h35);
        send_buffer();
        frame_bytes.push_back(8'h47);
        send_buffer();
        frame_bytes = '{8'h66, 8'h46, 8'h66, 8'h46, 8'h80};
        send_buffer();
        frame_bytes = '{8'h30, 8'h30};
        send_buffer();
    endtask

    task automatic test_random_buffers(input int target);
        while (bytes_sent < target) send_random_buffer();
    endtask

    // A stretch with neither side idling.
    task automatic test_steady_flow(input int count);
        int stop_at;
        stop_at      = bytes_sent + count;
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        while (bytes_sent < stop_at) send_random_buffer();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // The receiver holds off while the sender keeps offering bytes.
    task automatic test_output_holdoff();
        stall_request = 300;
        for (int i = 0; i < 4; i++) begin
            add_header(16'd24);
            add_random_bytes(20);
        end
        send_buffer();
    endtask

    // The sender pauses until every expected result has come back.
    task automatic test_drain_pause();
        send_random_buffer();
        wait_all_results();
        send_random_buffer();
    endtask

    // Output side: random stalls plus a long hold-off when requested.
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request > 0) begin
                m_axis_tready <= 1'b0;
                stall_request--;
            end else begin
                m_axis_tready <= !(sink_idle_on && $urandom_range(99) < 13);
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind           = t_kind'(m_axis_tuser[2:0]);
            got.run_last       = m_axis_tuser[3];
            got.payload_byte   = m_axis_tdata[7:0];
            got.payload_length = m_axis_tdata[23:8];
            got.packet_last    = m_axis_tlast;
            if (pending.size() == 0) begin
                note_failure($sformatf("unexpected result: kind=%0d byte=%h len=%0d plast=%b rlast=%b",
                                       got.kind, got.payload_byte, got.payload_length,
                                       got.packet_last, got.run_last));
            end else begin
                want = pending.pop_front();
                if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
                    got.payload_length !== want.payload_length ||
                    got.packet_last !== want.packet_last || got.run_last !== want.run_last) begin
                    note_failure($sformatf({"mismatch: expected kind=%0d byte=%h len=%0d ",
                                            "plast=%b rlast=%b, got kind=%0d byte=%h len=%0d ",
                                            "plast=%b rlast=%b"},
                                           want.kind, want.payload_byte, want.payload_length,
                                           want.packet_last, want.run_last, got.kind,
                                           got.payload_byte, got.payload_length,
                                           got.packet_last, got.run_last));
                end
            end
        end
    end

    // Reset, then the tests in turn.
    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_control_packets();
        test_random_buffers(500);
        test_steady_flow(300);
        test_output_holdoff();
        test_drain_pause();
        test_random_buffers(TARGET_BYTES);

        wait_all_results();
        repeat (10) @(posedge i_clk);
        if (pending.size() != 0) begin
            note_failure($sformatf("%0d expected results never arrived", pending.size()));
        end
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
